// File: rtl/npsched_pkg.sv
`timescale 1ns / 1ps
package npsched_pkg;

    localparam int TASK_SLOTS_DEF = 32;
    localparam int TIME_BITS_DEF  = 16;

    localparam int TASK_W     = 5;
    localparam int ARR_W      = 16;
    localparam int DUR_W      = 16;
    localparam int PRIO_W     = 8;
    localparam int OUT_TIME_W = 16;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_EMPTY   = 3'd0,
        ST_WAITING = 3'd1,
        ST_READY   = 3'd2,
        ST_RUNNING = 3'd3,
        ST_ENDED   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_END,
        S_SCAN,
        S_DISP
    } t_state;

    typedef struct packed {
        logic [ARR_W-1:0]  arrival;
        logic [DUR_W-1:0]  duration;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic load;
        logic tick_start;
        logic end_chk;
        logic scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_stat;

endpackage

// File: rtl/npsched_ctrl.sv
`timescale 1ns / 1ps
module npsched_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_kind,
    input  npsched_pkg::t_stat i_st,
    output logic               o_stall,
    output npsched_pkg::t_cmd  o_cmd
);

    npsched_pkg::t_state r_state;
    npsched_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= npsched_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            npsched_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (i_kind == npsched_pkg::KIND_TICK) begin
                        o_cmd.tick_start = 1'b1;
                        n_state          = npsched_pkg::S_END;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            npsched_pkg::S_END: begin
                o_cmd.end_chk = 1'b1;
                n_state       = npsched_pkg::S_SCAN;
            end
            npsched_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_st.scan_last) begin
                    n_state = npsched_pkg::S_DISP;
                end
            end
            npsched_pkg::S_DISP: begin
                if (i_st.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = npsched_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = npsched_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/npsched_dp.sv
`timescale 1ns / 1ps
module npsched_dp #(
    parameter int TASK_SLOTS = npsched_pkg::TASK_SLOTS_DEF,
    parameter int TIME_BITS  = npsched_pkg::TIME_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  npsched_pkg::t_cmd                  i_cmd,
    output npsched_pkg::t_stat                 o_st,
    input  logic [npsched_pkg::TASK_W-1:0]     i_task_index,
    input  logic [npsched_pkg::ARR_W-1:0]      i_arrival_time,
    input  logic [npsched_pkg::DUR_W-1:0]      i_exec_duration,
    input  logic [npsched_pkg::PRIO_W-1:0]     i_priority_req,
    input  logic                               i_stall,
    output logic                               o_valid,
    output logic [npsched_pkg::OUT_TIME_W-1:0] o_time_now,
    output logic                               o_running_valid,
    output logic [npsched_pkg::TASK_W-1:0]     o_running_task,
    output logic                               o_finished_valid,
    output logic [npsched_pkg::TASK_W-1:0]     o_finished_task
);

    localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

    // task table
    npsched_pkg::t_entry r_mem [TASK_SLOTS];
    npsched_pkg::t_entry r_rd;
    npsched_pkg::t_status r_status [TASK_SLOTS];

    logic                               r_busy;
    logic [SLOT_W-1:0]                  r_cur;
    logic [npsched_pkg::DUR_W-1:0]      r_ticks;
    logic [TIME_BITS-1:0]               r_clock;
    logic [SLOT_W-1:0]                  r_cnt;
    logic                               r_found;
    logic                               r_fin_valid;
    logic                               r_out_valid;
    logic [SLOT_W-1:0]                  r_fin_idx;
    logic [SLOT_W-1:0]                  r_best;
    logic [npsched_pkg::PRIO_W-1:0]     r_best_prio;
    logic [npsched_pkg::ARR_W-1:0]      r_best_arr;
    logic [npsched_pkg::OUT_TIME_W-1:0] r_o_time;
    logic                               r_o_run_v;
    logic [npsched_pkg::TASK_W-1:0]     r_o_run_t;
    logic                               r_o_fin_v;
    logic [npsched_pkg::TASK_W-1:0]     r_o_fin_t;

    logic              ld_ok;
    logic [SLOT_W-1:0] ld_addr;
    logic              ld_write;
    logic [SLOT_W-1:0] rd_addr;
    logic              scan_last;
    logic              out_free;
    logic              end_hit;
    logic              arr_hit;
    logic              cand_ready;
    logic              beats;
    logic              take;
    logic              do_disp;

    assign ld_ok    = int'(i_task_index) < TASK_SLOTS;
    assign ld_addr  = SLOT_W'(i_task_index);
    assign ld_write = i_cmd.load && ld_ok && (r_status[ld_addr] != npsched_pkg::ST_RUNNING);

    assign scan_last = (r_cnt == LAST_SLOT);
    assign out_free  = !r_out_valid || !i_stall;
    assign o_st      = '{scan_last: scan_last, out_free: out_free};

    always_comb begin
        if (i_cmd.tick_start) begin
            rd_addr = r_cur;
        end else if (i_cmd.end_chk || scan_last) begin
            rd_addr = '0;
        end else begin
            rd_addr = r_cnt + SLOT_W'(1);
        end
    end

    assign end_hit    = (r_ticks >= r_rd.duration);
    assign arr_hit    = i_cmd.scan && (r_status[r_cnt] == npsched_pkg::ST_WAITING)
                        && (TIME_BITS'(r_rd.arrival) == r_clock);
    assign cand_ready = (r_status[r_cnt] == npsched_pkg::ST_READY) || arr_hit;
    assign beats      = (r_rd.prio > r_best_prio)
                        || ((r_rd.prio == r_best_prio) && (r_rd.arrival < r_best_arr));
    assign take       = i_cmd.scan && !r_busy && cand_ready && (!r_found || beats);
    assign do_disp    = i_cmd.commit && !r_busy && r_found;

    always_ff @(posedge i_clk) begin
        if (ld_write) begin
            r_mem[ld_addr] <= '{arrival: i_arrival_time, duration: i_exec_duration,
                                prio: i_priority_req};
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TASK_SLOTS; k++) begin
                r_status[k] <= npsched_pkg::ST_EMPTY;
            end
        end else begin
            if (ld_write) begin
                r_status[ld_addr] <= npsched_pkg::ST_WAITING;
            end
            if (i_cmd.end_chk && r_busy && end_hit) begin
                r_status[r_cur] <= npsched_pkg::ST_ENDED;
            end
            if (arr_hit) begin
                r_status[r_cnt] <= npsched_pkg::ST_READY;
            end
            if (do_disp) begin
                r_status[r_best] <= npsched_pkg::ST_RUNNING;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cur       <= '0;
            r_ticks     <= '0;
            r_clock     <= '0;
            r_cnt       <= '0;
            r_found     <= 1'b0;
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.end_chk) begin
                r_cnt       <= '0;
                r_found     <= 1'b0;
                r_fin_valid <= r_busy && end_hit;
                if (r_busy) begin
                    if (end_hit) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_ticks <= r_ticks + npsched_pkg::DUR_W'(1);
                    end
                end
            end
            if (i_cmd.scan) begin
                r_cnt <= r_cnt + SLOT_W'(1);
                if (take) begin
                    r_found <= 1'b1;
                end
            end
            if (do_disp) begin
                r_busy  <= 1'b1;
                r_cur   <= r_best;
                r_ticks <= npsched_pkg::DUR_W'(1);
            end
            if (i_cmd.commit) begin
                r_clock     <= r_clock + TIME_BITS'(1);
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.end_chk) begin
            r_fin_idx <= r_cur;
        end
        if (take) begin
            r_best      <= r_cnt;
            r_best_prio <= r_rd.prio;
            r_best_arr  <= r_rd.arrival;
        end
        if (i_cmd.commit) begin
            r_o_time  <= npsched_pkg::OUT_TIME_W'(r_clock);
            r_o_run_v <= r_busy || r_found;
            if (r_busy) begin
                r_o_run_t <= npsched_pkg::TASK_W'(r_cur);
            end else if (r_found) begin
                r_o_run_t <= npsched_pkg::TASK_W'(r_best);
            end else begin
                r_o_run_t <= '0;
            end
            r_o_fin_v <= r_fin_valid;
            r_o_fin_t <= r_fin_valid ? npsched_pkg::TASK_W'(r_fin_idx) : '0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_time_now       = r_o_time;
    assign o_running_valid  = r_o_run_v;
    assign o_running_task   = r_o_run_t;
    assign o_finished_valid = r_o_fin_v;
    assign o_finished_task  = r_o_fin_t;

    a_busy_slot_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_status[r_cur] == npsched_pkg::ST_RUNNING))
        else $error("busy processor without a running slot");

    a_busy_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_ticks != '0))
        else $error("running task with zero ticks");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || !i_stall))
        else $error("result overwritten while still pending");

    a_single_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.load, i_cmd.tick_start, i_cmd.end_chk, i_cmd.scan, i_cmd.commit}))
        else $error("more than one datapath command");

endmodule

// File: rtl/nonpreemptive_priority_scheduler.sv
// non-preemptive priority scheduler
// input channel: i_valid / o_stall carries one word per item; i_kind selects
//   a task load (slot, arrival, duration, priority) or one time tick
// output channel: o_valid / i_stall carries one word per tick: time, running
//   task and the task that finished at the start of the tick; loads give none
// a load is accepted while idle and writes the task table directly, unless its
//   slot is out of range or holds the running task
// a tick reads the running task's length, ends or advances it, scans every
//   slot of the task table for arrivals and the best ready task, and then
//   dispatches and registers the result
// the result sits in an output register; the next item is accepted while it
//   waits, and a later tick holds in its dispatch cycle until the receiver
//   takes the pending word
// reset clears all slot states to empty, the clock, the processor and the
//   output valid flag; the output data and task table contents are left as they were
`timescale 1ns / 1ps
module nonpreemptive_priority_scheduler #(
    parameter int TASK_SLOTS = npsched_pkg::TASK_SLOTS_DEF,
    parameter int TIME_BITS  = npsched_pkg::TIME_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_kind,
    input  logic [npsched_pkg::TASK_W-1:0]     i_task_index,
    input  logic [npsched_pkg::ARR_W-1:0]      i_arrival_time,
    input  logic [npsched_pkg::DUR_W-1:0]      i_exec_duration,
    input  logic [npsched_pkg::PRIO_W-1:0]     i_priority_req,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [npsched_pkg::OUT_TIME_W-1:0] o_time_now,
    output logic                               o_running_valid,
    output logic [npsched_pkg::TASK_W-1:0]     o_running_task,
    output logic                               o_finished_valid,
    output logic [npsched_pkg::TASK_W-1:0]     o_finished_task
);

    npsched_pkg::t_cmd  cmd;
    npsched_pkg::t_stat st;

    npsched_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .i_st    (st),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    npsched_dp #(
        .TASK_SLOTS (TASK_SLOTS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_st             (st),
        .i_task_index     (i_task_index),
        .i_arrival_time   (i_arrival_time),
        .i_exec_duration  (i_exec_duration),
        .i_priority_req   (i_priority_req),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_time_now       (o_time_now),
        .o_running_valid  (o_running_valid),
        .o_running_task   (o_running_task),
        .o_finished_valid (o_finished_valid),
        .o_finished_task  (o_finished_task)
    );

endmodule
